@@ hw/rtl/epipolar_distance_error_sum_macros.svh @@
// ----------------------------------------------------------------------------
// Epipolar distance error sum: assertion macros
// Shared concurrent checks, clocked by clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef EPIPOLAR_DISTANCE_ERROR_SUM_MACROS_SVH
`define EPIPOLAR_DISTANCE_ERROR_SUM_MACROS_SVH

// same-cycle implication
`define EDS_ASSERT_IMPLY(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication
`define EDS_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ hw/rtl/eds_pkg.sv @@
// ----------------------------------------------------------------------------
// eds_pkg
// Types, constants and the multiply sequence of the epipolar error block.
// ----------------------------------------------------------------------------
`default_nettype none

package eds_pkg;

    localparam int EssDepth = 9;
    localparam logic [5:0] LastStep = 6'd37;
    localparam logic signed [31:0] OneQ16 = 32'sd65536;
    localparam logic signed [31:0] OneQ24 = 32'sd16777216;
    localparam logic signed [31:0] OneQ28 = 32'sd268435456;
    localparam logic [31:0] SatU32 = 32'hFFFF_FFFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_PAIR = 1'b1;

    typedef enum logic [2:0] {
        CFG_K00, CFG_K01, CFG_K02, CFG_K11, CFG_K12
    } cfg_idx_t;

    // multiplier operand sources
    typedef enum logic [4:0] {
        SRC_K00, SRC_K01, SRC_K02, SRC_K11, SRC_K12, SRC_E,
        SRC_X1, SRC_Y1, SRC_X2, SRC_Y2, SRC_ONE16, SRC_ONE24,
        SRC_N1X, SRC_N1Y, SRC_N2X, SRC_N2Y,
        SRC_L20, SRC_L21, SRC_L22, SRC_L10, SRC_L11, SRC_L12
    } src_t;

    // where a finished dot product goes; D_NONE: group continues
    typedef enum logic [3:0] {
        D_NONE, D_N1X, D_N1Y, D_N2X, D_N2Y,
        D_L20, D_L21, D_L22, D_L10, D_L11, D_L12,
        D_NUM2, D_SQ2, D_NUM1, D_SQ1
    } dst_t;

    typedef struct packed {
        src_t       a;
        src_t       b;
        logic [3:0] e_idx;
        logic       floor2;
        dst_t       dst;
    } step_t;

    function automatic step_t step_desc(input logic [5:0] s);
        step_t d;
        d = '{SRC_K00, SRC_X1, 4'd0, 1'b1, D_NONE};
        case (s)
            // film-plane points
            6'd0:  d = '{SRC_K00, SRC_X1,    4'd0, 1'b1, D_NONE};
            6'd1:  d = '{SRC_K01, SRC_Y1,    4'd0, 1'b1, D_NONE};
            6'd2:  d = '{SRC_K02, SRC_ONE16, 4'd0, 1'b1, D_N1X};
            6'd3:  d = '{SRC_K11, SRC_Y1,    4'd0, 1'b1, D_NONE};
            6'd4:  d = '{SRC_K12, SRC_ONE16, 4'd0, 1'b1, D_N1Y};
            6'd5:  d = '{SRC_K00, SRC_X2,    4'd0, 1'b1, D_NONE};
            6'd6:  d = '{SRC_K01, SRC_Y2,    4'd0, 1'b1, D_NONE};
            6'd7:  d = '{SRC_K02, SRC_ONE16, 4'd0, 1'b1, D_N2X};
            6'd8:  d = '{SRC_K11, SRC_Y2,    4'd0, 1'b1, D_NONE};
            6'd9:  d = '{SRC_K12, SRC_ONE16, 4'd0, 1'b1, D_N2Y};
            // l2 = E * n1
            6'd10: d = '{SRC_E, SRC_N1X,   4'd0, 1'b1, D_NONE};
            6'd11: d = '{SRC_E, SRC_N1Y,   4'd1, 1'b1, D_NONE};
            6'd12: d = '{SRC_E, SRC_ONE24, 4'd2, 1'b1, D_L20};
            6'd13: d = '{SRC_E, SRC_N1X,   4'd3, 1'b1, D_NONE};
            6'd14: d = '{SRC_E, SRC_N1Y,   4'd4, 1'b1, D_NONE};
            6'd15: d = '{SRC_E, SRC_ONE24, 4'd5, 1'b1, D_L21};
            6'd16: d = '{SRC_E, SRC_N1X,   4'd6, 1'b1, D_NONE};
            6'd17: d = '{SRC_E, SRC_N1Y,   4'd7, 1'b1, D_NONE};
            6'd18: d = '{SRC_E, SRC_ONE24, 4'd8, 1'b1, D_L22};
            // l1 = E^T * n2
            6'd19: d = '{SRC_E, SRC_N2X,   4'd0, 1'b1, D_NONE};
            6'd20: d = '{SRC_E, SRC_N2Y,   4'd3, 1'b1, D_NONE};
            6'd21: d = '{SRC_E, SRC_ONE24, 4'd6, 1'b1, D_L10};
            6'd22: d = '{SRC_E, SRC_N2X,   4'd1, 1'b1, D_NONE};
            6'd23: d = '{SRC_E, SRC_N2Y,   4'd4, 1'b1, D_NONE};
            6'd24: d = '{SRC_E, SRC_ONE24, 4'd7, 1'b1, D_L11};
            6'd25: d = '{SRC_E, SRC_N2X,   4'd2, 1'b1, D_NONE};
            6'd26: d = '{SRC_E, SRC_N2Y,   4'd5, 1'b1, D_NONE};
            6'd27: d = '{SRC_E, SRC_ONE24, 4'd8, 1'b1, D_L12};
            // numerators and squared norms, raw squares
            6'd28: d = '{SRC_L20, SRC_N2X,   4'd0, 1'b1, D_NONE};
            6'd29: d = '{SRC_L21, SRC_N2Y,   4'd0, 1'b1, D_NONE};
            6'd30: d = '{SRC_L22, SRC_ONE24, 4'd0, 1'b1, D_NUM2};
            6'd31: d = '{SRC_L20, SRC_L20,   4'd0, 1'b0, D_NONE};
            6'd32: d = '{SRC_L21, SRC_L21,   4'd0, 1'b0, D_SQ2};
            6'd33: d = '{SRC_L10, SRC_N1X,   4'd0, 1'b1, D_NONE};
            6'd34: d = '{SRC_L11, SRC_N1Y,   4'd0, 1'b1, D_NONE};
            6'd35: d = '{SRC_L12, SRC_ONE24, 4'd0, 1'b1, D_NUM1};
            6'd36: d = '{SRC_L10, SRC_L10,   4'd0, 1'b0, D_NONE};
            6'd37: d = '{SRC_L11, SRC_L11,   4'd0, 1'b0, D_SQ1};
            default: d = '{SRC_K00, SRC_X1, 4'd0, 1'b1, D_NONE};
        endcase
        return d;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SatU32 : s[31:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/epipolar_distance_error_sum.sv @@
// Loads: a matrix load transfer is registered into the essential matrix when accepted; a point
// pair runs from input transfer to output register through the multiply sequence, the root
// and the divider, shorter if a line is flat or a distance saturates early, plus any output stall.
// Throughput: loads back to back; pairs one at a time, a new pair taken only once the last
// reaches the output register, as the shared 32x32 multiplier (38 products) and the serial root/divider carry one pair.
// Reset: asynchronous active low; identity camera matrix, zero essential matrix and total.
`default_nettype none
`include "epipolar_distance_error_sum_macros.svh"

// ----------------------------------------------------------------------------
// epipolar_distance_error_sum
// Symmetric epipolar distance of pixel pairs against a loaded essential
// matrix, with a saturating running total per set.
// ----------------------------------------------------------------------------
module epipolar_distance_error_sum (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration writes
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    // input stream
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // entry_index, entry_value, first_x, first_y, second_x, second_y, zero pad
    input  wire logic [167:0] s_axis_tdata,
    input  wire logic         s_axis_tuser,   // operation
    input  wire logic         s_axis_tlast,   // final_pair
    // output stream
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // pair_error, running_total
    output logic              m_axis_tuser,   // degenerate
    output logic              m_axis_tlast    // set_done
);
    import eds_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_FIN, S_ROOT, S_DIV, S_SUM, S_HOLD
    } state_t;

    state_t state_reg;

    // configuration, Q4.28
    logic signed [31:0] k00_reg, k01_reg, k02_reg, k11_reg, k12_reg;
    logic signed [31:0] ess_reg [0:EssDepth-1];

    // captured pair
    logic signed [31:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic               last_reg;

    // intermediates: points and lines Q8.24, numerators and squared norms 64-bit
    logic signed [31:0] n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic signed [31:0] l20_reg, l21_reg, l22_reg, l10_reg, l11_reg, l12_reg;
    logic signed [63:0] num1_reg, num2_reg;
    logic [63:0]        sq1_reg, sq2_reg;

    // multiply-accumulate datapath
    logic [5:0]         step_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    step_t              desc;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] term;
    logic signed [63:0] rnd18, rnd26;
    logic signed [31:0] r18, r26;

    // distance stage
    logic               line_reg;
    logic               root_start_reg, div_start_reg;
    logic               root_done, div_done;
    logic [31:0]        root, quot;
    logic signed [63:0] num_sel;
    logic [63:0]        mag;
    logic [31:0]        dist0_reg, dist1_reg, err_reg;
    logic               degen_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        total;

    // output register
    logic               out_valid_reg;
    logic [31:0]        out_err_reg, out_total_reg;
    logic               out_degen_reg, out_last_reg;

    logic [3:0]         in_idx;
    logic signed [31:0] in_val;

    assign in_idx = s_axis_tdata[3:0];
    assign in_val = s_axis_tdata[35:4];

    function automatic logic signed [31:0] pick(input src_t s, input logic [3:0] e);
        logic signed [31:0] v;
        case (s)
            SRC_K00:   v = k00_reg;
            SRC_K01:   v = k01_reg;
            SRC_K02:   v = k02_reg;
            SRC_K11:   v = k11_reg;
            SRC_K12:   v = k12_reg;
            SRC_E:     v = ess_reg[e];
            SRC_X1:    v = x1_reg;
            SRC_Y1:    v = y1_reg;
            SRC_X2:    v = x2_reg;
            SRC_Y2:    v = y2_reg;
            SRC_ONE16: v = OneQ16;
            SRC_ONE24: v = OneQ24;
            SRC_N1X:   v = n1x_reg;
            SRC_N1Y:   v = n1y_reg;
            SRC_N2X:   v = n2x_reg;
            SRC_N2Y:   v = n2y_reg;
            SRC_L20:   v = l20_reg;
            SRC_L21:   v = l21_reg;
            SRC_L22:   v = l22_reg;
            SRC_L10:   v = l10_reg;
            SRC_L11:   v = l11_reg;
            SRC_L12:   v = l12_reg;
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        desc  = step_desc(step_reg);
        op_a  = pick(desc.a, desc.e_idx);
        op_b  = pick(desc.b, desc.e_idx);
        // products floored by two bits, squares taken whole
        term  = desc.floor2 ? (prod_reg >>> 2) : prod_reg;
        // round half up: points to Q8.24 from Q.42, lines from Q.50
        rnd18 = (acc_reg + 64'sd131072) >>> 18;
        rnd26 = (acc_reg + 64'sd33554432) >>> 26;
        r18   = sat32(rnd18);
        r26   = sat32(rnd26);
    end

    // line 0 is l2 against n2, line 1 is l1 against n1
    assign num_sel = line_reg ? num1_reg : num2_reg;
    assign mag     = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
    assign total   = sat_add(sum_reg, err_reg);

    eds_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start_reg),
        .radicand (line_reg ? sq1_reg : sq2_reg),
        .done     (root_done),
        .root     (root)
    );

    eds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (mag),
        .divisor  (root),
        .done     (div_done),
        .quot     (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k00_reg        <= OneQ28;
            k01_reg        <= '0;
            k02_reg        <= '0;
            k11_reg        <= OneQ28;
            k12_reg        <= '0;
            for (int i = 0; i < EssDepth; i++)
                ess_reg[i] <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            root_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            step_reg       <= '0;
            line_reg       <= 1'b0;
            degen_reg      <= 1'b0;
        end
        else
        begin
            root_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_K00: k00_reg <= cfg_data;
                    CFG_K01: k01_reg <= cfg_data;
                    CFG_K02: k02_reg <= cfg_data;
                    CFG_K11: k11_reg <= cfg_data;
                    CFG_K12: k12_reg <= cfg_data;
                    default: ;
                endcase
            end

            // S_HOLD handles its own refill of the output register
            if (out_valid_reg && m_axis_tready && (state_reg != S_HOLD))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        if (s_axis_tuser == OP_LOAD)
                        begin
                            if (in_idx < 4'(EssDepth))
                                ess_reg[in_idx] <= in_val;
                        end
                        else
                        begin
                            x1_reg    <= s_axis_tdata[67:36];
                            y1_reg    <= s_axis_tdata[99:68];
                            x2_reg    <= s_axis_tdata[131:100];
                            y2_reg    <= s_axis_tdata[163:132];
                            last_reg  <= s_axis_tlast;
                            step_reg  <= '0;
                            acc_reg   <= '0;
                            degen_reg <= 1'b0;
                            line_reg  <= 1'b0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= op_a * op_b;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    acc_reg <= acc_reg + term;
                    if (desc.dst == D_NONE)
                    begin
                        step_reg  <= step_reg + 6'd1;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    case (desc.dst)
                        D_N1X:   n1x_reg  <= r18;
                        D_N1Y:   n1y_reg  <= r18;
                        D_N2X:   n2x_reg  <= r18;
                        D_N2Y:   n2y_reg  <= r18;
                        D_L20:   l20_reg  <= r26;
                        D_L21:   l21_reg  <= r26;
                        D_L22:   l22_reg  <= r26;
                        D_L10:   l10_reg  <= r26;
                        D_L11:   l11_reg  <= r26;
                        D_L12:   l12_reg  <= r26;
                        D_NUM2:  num2_reg <= acc_reg;
                        D_SQ2:   sq2_reg  <= acc_reg;
                        D_NUM1:  num1_reg <= acc_reg;
                        D_SQ1:   sq1_reg  <= acc_reg;
                        default: ;
                    endcase
                    acc_reg <= '0;
                    if (step_reg == LastStep)
                    begin
                        root_start_reg <= 1'b1;
                        state_reg      <= S_ROOT;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 6'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_ROOT:
                begin
                    if (root_done)
                    begin
                        if (root == 32'd0)
                        begin
                            // flat line: distance saturates
                            degen_reg <= 1'b1;
                            if (!line_reg)
                            begin
                                dist0_reg      <= SatU32;
                                line_reg       <= 1'b1;
                                root_start_reg <= 1'b1;
                            end
                            else
                            begin
                                dist1_reg <= SatU32;
                                state_reg <= S_SUM;
                            end
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (!line_reg)
                        begin
                            dist0_reg      <= quot;
                            line_reg       <= 1'b1;
                            root_start_reg <= 1'b1;
                            state_reg      <= S_ROOT;
                        end
                        else
                        begin
                            dist1_reg <= quot;
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    err_reg   <= sat_add(dist0_reg, dist1_reg);
                    state_reg <= S_HOLD;
                end
                S_HOLD:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_err_reg   <= err_reg;
                        out_total_reg <= total;
                        out_degen_reg <= degen_reg;
                        out_last_reg  <= last_reg;
                        sum_reg       <= last_reg ? 32'd0 : total;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_total_reg, out_err_reg};
    assign m_axis_tuser  = out_degen_reg;
    assign m_axis_tlast  = out_last_reg;

    `EDS_ASSERT_NEXT(a_total_clears_after_last,
        (state_reg == S_HOLD) && (!out_valid_reg || m_axis_tready) && last_reg,
        sum_reg == 32'd0, "running total not cleared after final pair")
    `EDS_ASSERT_IMPLY(a_total_covers_error, m_axis_tvalid,
        m_axis_tdata[63:32] >= m_axis_tdata[31:0], "running total below pair error")
    `EDS_ASSERT_IMPLY(a_degenerate_saturates, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[31:0] == SatU32, "degenerate pair without saturated error")
    `EDS_ASSERT_NEXT(a_zero_norm_flags, (state_reg == S_ROOT) && root_done && (root == 32'd0),
        degen_reg, "zero line norm did not raise degenerate")

endmodule

`default_nettype wire

@@ hw/rtl/eds_sqrt.sv @@
// ----------------------------------------------------------------------------
// eds_sqrt
// Bit-serial integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= radicand;
                res_reg  <= '0;
                bit_reg  <= 64'h4000_0000_0000_0000;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

`default_nettype wire

@@ hw/rtl/eds_div.sv @@
// ----------------------------------------------------------------------------
// eds_div
// Rounded distance quotient (num + d/2) / d with d = norm * 64, one bit per
// cycle, saturating at 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module eds_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quot
);
    import eds_pkg::*;

    typedef enum logic [1:0] {P_IDLE, P_CHECK, P_RUN} phase_t;

    phase_t      phase_reg;
    logic [63:0] num_reg;
    logic [37:0] den_reg;
    logic [37:0] rem_reg;
    logic [31:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [38:0] trial;
    logic        ge;

    assign trial = {rem_reg, num_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        num_reg   <= dividend + {27'd0, divisor, 5'd0};
                        den_reg   <= {divisor, 6'd0};
                        phase_reg <= P_CHECK;
                    end
                end
                P_CHECK:
                begin
                    // upper half already reaching d means a quotient past 32 bits
                    if ({6'd0, num_reg[63:32]} >= den_reg)
                    begin
                        quo_reg   <= SatU32;
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= {6'd0, num_reg[63:32]};
                        cnt_reg   <= '0;
                        phase_reg <= P_RUN;
                    end
                end
                P_RUN:
                begin
                    rem_reg <= ge ? 38'(trial - {1'b0, den_reg}) : trial[37:0];
                    num_reg <= {num_reg[62:0], 1'b0};
                    quo_reg <= {quo_reg[30:0], ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        done_reg  <= 1'b1;
                        phase_reg <= P_IDLE;
                    end
                end
                default: phase_reg <= P_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: epipolar distance error sum testbench
// Loads essential matrices and streams point pairs; a behavioral predictor
// computes the pair error and running total, and a scoreboard checks each
// output transfer in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import eds_pkg::*;

    typedef struct packed {
        logic [31:0] pair_error;
        logic [31:0] running_total;
        logic        degenerate;
        logic        set_done;
    } epi_result_t;

    // scoreboard: predictor state plus the queue of expected output transfers
    class epi_scoreboard;
        logic signed [31:0] kmat [5];
        logic signed [31:0] ess [9];
        logic [31:0] total_acc;
        epi_result_t pending [$];
        int mismatches;

        function void clear();
            kmat[0] = OneQ28;
            kmat[1] = 0;
            kmat[2] = 0;
            kmat[3] = OneQ28;
            kmat[4] = 0;
            foreach (ess[i]) ess[i] = 0;
            total_acc = 0;
            mismatches = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] v);
            if (idx < 5) kmat[idx] = v;
        endfunction

        // floor(a*b / 4)
        function logic signed [63:0] prod4(logic signed [31:0] a, logic signed [31:0] b);
            logic signed [63:0] p;
            p = 64'(a) * 64'(b);
            return p >>> 2;
        endfunction

        function logic signed [31:0] rnd_sat(logic signed [63:0] v, int s);
            logic signed [63:0] r;
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
            if (r > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (r < -64'sd2147483648) return 32'sh8000_0000;
            return r[31:0];
        endfunction

        function logic [63:0] root64(logic [63:0] v);
            logic [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function logic [31:0] distance(logic signed [31:0] l [3],
                                       logic signed [31:0] p [3], inout logic dg);
            logic signed [63:0] num;
            logic [63:0] mag, sq, nrm, d, q;
            num = prod4(l[0], p[0]) + prod4(l[1], p[1]) + prod4(l[2], p[2]);
            mag = num < 0 ? -num : num;
            sq = 64'(64'(l[0]) * 64'(l[0])) + 64'(64'(l[1]) * 64'(l[1]));
            nrm = root64(sq);
            if (nrm == 0)
            begin
                dg = 1;
                return 32'hFFFF_FFFF;
            end
            d = nrm << 6;
            q = (mag + (d >> 1)) / d;
            return q > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : q[31:0];
        endfunction

        // note one accepted input transfer
        function void note_input(logic op, logic [3:0] idx, logic signed [31:0] val,
                                 logic signed [31:0] x1, logic signed [31:0] y1,
                                 logic signed [31:0] x2, logic signed [31:0] y2,
                                 logic fin);
            logic signed [31:0] n1 [3], n2 [3], l1 [3], l2 [3];
            logic dg;
            logic [31:0] err, tot;
            epi_result_t r;
            if (op == OP_LOAD)
            begin
                if (idx < 9) ess[idx] = val;
                return;
            end
            n1[0] = rnd_sat(prod4(kmat[0], x1) + prod4(kmat[1], y1)
                            + prod4(kmat[2], OneQ16), 18);
            n1[1] = rnd_sat(prod4(kmat[3], y1) + prod4(kmat[4], OneQ16), 18);
            n1[2] = OneQ24;
            n2[0] = rnd_sat(prod4(kmat[0], x2) + prod4(kmat[1], y2)
                            + prod4(kmat[2], OneQ16), 18);
            n2[1] = rnd_sat(prod4(kmat[3], y2) + prod4(kmat[4], OneQ16), 18);
            n2[2] = OneQ24;
            for (int i = 0; i < 3; i++)
            begin
                l2[i] = rnd_sat(prod4(ess[3*i], n1[0]) + prod4(ess[3*i+1], n1[1])
                                + prod4(ess[3*i+2], n1[2]), 26);
                l1[i] = rnd_sat(prod4(ess[i], n2[0]) + prod4(ess[3+i], n2[1])
                                + prod4(ess[6+i], n2[2]), 26);
            end
            dg = 0;
            err = distance(l2, n2, dg);
            err = add_sat(err, distance(l1, n1, dg));
            tot = add_sat(total_acc, err);
            total_acc = fin ? 32'd0 : tot;
            r.pair_error = err;
            r.running_total = tot;
            r.degenerate = dg;
            r.set_done = fin;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(epi_result_t got);
            epi_result_t w;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output transfer %p", got);
                return;
            end
            w = pending.pop_front();
            if (got !== w)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected err %h tot %h dg %b done %b, got %h %h %b %b",
                             w.pair_error, w.running_total, w.degenerate, w.set_done,
                             got.pair_error, got.running_total, got.degenerate, got.set_done);
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = 0;
    logic [31:0]  cfg_data = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = 0;   // entry_index, entry_value, x1, y1, x2, y2, pad
    logic         s_axis_tuser = 0;   // operation
    logic         s_axis_tlast = 0;   // final_pair
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [63:0]  m_axis_tdata;       // pair_error, running_total
    logic         m_axis_tuser;       // degenerate
    logic         m_axis_tlast;       // set_done

    epi_scoreboard sb;
    int cycles = 0;
    bit out_idle_en = 1;   // cleared during the no-stall stretch
    bit in_idle_en = 1;

    always #1 clk = ~clk;

    epipolar_distance_error_sum uut (.*);

    // run time grows with every output stall
    localparam int CycleLimit = 1_500_000;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // output side: random back-pressure, check every output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result({m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tuser, m_axis_tlast});
            m_axis_tready <= out_idle_en ? ($urandom_range(99) >= 29) : 1'b1;
        end
    end

    task automatic cfg_write(int idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx[2:0];
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    // one input transfer; random idle gaps before it, tvalid stays up otherwise
    task automatic send_item(logic op, logic [3:0] idx, logic [31:0] val,
                             logic [31:0] x1, logic [31:0] y1,
                             logic [31:0] x2, logic [31:0] y2, logic fin);
        while (in_idle_en && $urandom_range(99) < 29)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tlast <= fin;
        s_axis_tdata <= {4'd0, y2, x2, y1, x1, val, idx};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(op, idx, val, x1, y1, x2, y2, fin);
    endtask

    task automatic load_entry(int idx, logic [31:0] v);
        send_item(OP_LOAD, idx[3:0], v, $urandom, $urandom, $urandom, $urandom,
                  1'($urandom));
    endtask

    task automatic send_pair(logic [31:0] x1, logic [31:0] y1,
                             logic [31:0] x2, logic [31:0] y2, logic fin);
        send_item(OP_PAIR, 4'($urandom), $urandom, x1, y1, x2, y2, fin);
    endtask

    // pixel coordinate: mostly moderate values, sometimes the full range
    function automatic logic [31:0] pix();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000 << 16)) - (1000 << 16));
        endcase
    endfunction

    // matrix entry: mostly near unit scale, sometimes extreme or zero
    function automatic logic [31:0] entry();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 0;
            default: return 32'($signed($urandom_range(1 << 29)) - (1 << 28));
        endcase
    endfunction

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // identity-ish intrinsics for a camera with focal 500 px, center 320/240
    task automatic cfg_camera();
        cfg_write(CFG_K00, 32'd536871);
        cfg_write(CFG_K01, 32'd0);
        cfg_write(CFG_K02, 32'hF5C28F5C);
        cfg_write(CFG_K11, 32'd536871);
        cfg_write(CFG_K12, 32'hF851EB85);
    endtask

    initial
    begin
        int npairs;
        sb = new();
        sb.clear();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: zero matrix gives degenerate lines
        send_pair(0, 0, 0, 0, 1'b0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        // pure translation along x, then a skewed matrix with extreme entries
        load_entry(5, 32'hF000_0000);
        load_entry(7, 32'h1000_0000);
        load_entry(9, 32'h7FFF_FFFF);    // ignored index
        load_entry(15, 32'h8000_0000);   // ignored index
        send_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 1'b0);
        send_pair(32'h0010_0000, 32'hFFF0_0000, 32'h0010_0000, 32'h0010_0000, 1'b0);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        for (int i = 0; i < 9; i++) load_entry(i, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000);
        send_pair(32'hFFFF_FFFF, 32'h1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_pair(32'h1234_5678, 32'hEDCB_A987, 0, 32'hFFFF_FFFF, 1'b1);
        drain();

        // register extremes, with the sender held until every result is back
        cfg_write(CFG_K00, 32'h7FFF_FFFF);
        cfg_write(CFG_K01, 32'h8000_0000);
        cfg_write(CFG_K02, 32'h7FFF_FFFF);
        cfg_write(CFG_K11, 32'h8000_0000);
        cfg_write(CFG_K12, 32'hFFFF_FFFF);
        cfg_write(5, 32'h1234_5678);     // out-of-range register index
        send_pair(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_pair(pix(), pix(), pix(), pix(), 1'b1);
        drain();

        // random phases: camera setting, reset values, random registers
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 3)
                0: cfg_camera();
                1: for (int r = 0; r < 5; r++)
                       cfg_write(r, (r == 0 || r == 3) ? OneQ28 : 32'd0);
                default: for (int r = 0; r < 5; r++) cfg_write(r, entry());
            endcase
            in_idle_en = (ph != 2);
            out_idle_en = (ph != 2);
            for (int m = 0; m < 17; m++)
            begin
                // well-formed matrix load, occasionally a stray or partial one
                for (int i = 0; i < 9; i++)
                    if ($urandom_range(19) != 0) load_entry(i, entry());
                if ($urandom_range(7) == 0) load_entry($urandom_range(15), $urandom);
                npairs = $urandom_range(1, 16);
                for (int p = 0; p < npairs; p++)
                    send_pair(pix(), pix(), pix(), pix(), p == npairs - 1);
            end
            drain();
        end
        in_idle_en = 1;
        out_idle_en = 1;

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

`default_nettype wire
